@@ sv/sbr_pkg.sv @@
// Shared types and constants for the stream byte reassembler.
// No dependencies; imported by sbr_cell, sbr_run_count and the top level.
`default_nettype none

package sbr_pkg;

  // Reassembly window depth, one cell per byte position
  localparam int WINDOW_DEPTH = 64;
  // Cell index width and width of a count of 0..WINDOW_DEPTH
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  // Run counter works on groups of eight cells
  localparam int GRP_W        = 8;
  localparam int NUM_GRP      = (WINDOW_DEPTH + GRP_W - 1) / GRP_W;
  localparam int LEAD_W       = $clog2(GRP_W + 1);
  // Fixed field widths
  localparam int POS_W        = 32;
  localparam int WIN_W        = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_CNT1,
    ST_CNT2,
    ST_FIN,
    ST_EMIT
  } sbr_state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic       clr;    // drop held byte (stream closed)
    logic       shift;  // take the neighbor's contents
    logic       wr;     // store the request's byte here
    logic [7:0] wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sbr_cell.sv @@
// One window cell: a held byte and its valid bit.
// Depends on sbr_pkg for the control struct.
`default_nettype none

module sbr_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sbr_pkg::cell_ctrl_t ctrl,
  input  logic              nb_vld,
  input  logic [7:0]        nb_dat,
  output logic              vld,
  output logic [7:0]        dat
);
  import sbr_pkg::*;

  logic       vld_r;
  logic [7:0] dat_r;

  // valid bit: clear wins, then shift toward the head, then store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      priority if (ctrl.clr) begin
        vld_r <= 1'b0;
      end else if (ctrl.shift) begin
        vld_r <= nb_vld;
      end else if (ctrl.wr) begin
        vld_r <= 1'b1;
      end else begin
        vld_r <= vld_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      dat_r <= nb_dat;
    end else if (ctrl.wr) begin
      dat_r <= ctrl.wdata;
    end else begin
      dat_r <= dat_r;
    end
  end

  assign vld = vld_r;
  assign dat = dat_r;

endmodule

`default_nettype wire

@@ sv/sbr_run_count.sv @@
// Two-stage registered count of contiguous valid cells from the head.
// Depends on sbr_pkg for depth and group constants.
`default_nettype none

module sbr_run_count (
  input  logic                       clk,
  input  logic [sbr_pkg::WINDOW_DEPTH-1:0] vld_vec,
  output logic [sbr_pkg::CNT_W-1:0]  run_len
);
  import sbr_pkg::*;

  localparam int PAD_W = NUM_GRP * GRP_W;

  logic [PAD_W-1:0]      vld_pad;
  logic [LEAD_W-1:0]     lead_r [NUM_GRP];
  logic [NUM_GRP-1:0]    full_r;
  logic [CNT_W-1:0]      run_r;

  assign vld_pad = PAD_W'(vld_vec);

  // stage 1: leading-ones count inside each group of eight
  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GRP; g++) begin
      logic              cont;
      logic [LEAD_W-1:0] cnt;
      cont = 1'b1;
      cnt  = '0;
      for (int j = 0; j < GRP_W; j++) begin
        if (cont && vld_pad[g*GRP_W + j]) begin
          cnt = cnt + 1'b1;
        end else begin
          cont = 1'b0;
        end
      end
      lead_r[g] <= cnt;
      full_r[g] <= cont;
    end
  end

  // stage 2: sum groups up to the first one with a hole
  always_ff @(posedge clk) begin
    logic             cont;
    logic [CNT_W-1:0] tot;
    cont = 1'b1;
    tot  = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      if (cont) begin
        tot = tot + CNT_W'(lead_r[g]);
      end
      if (!full_r[g]) begin
        cont = 1'b0;
      end
    end
    run_r <= tot;
  end

  assign run_len = run_r;

endmodule

`default_nettype wire

@@ sv/stream_byte_reassembler.sv @@
// Top level of the stream byte reassembler: sequencer, stream pointers,
// cell row and run counter. Depends on sbr_pkg, sbr_cell, sbr_run_count.
//
//  channel   handshake            payload
//  --------  -------------------  -----------------------------------------------
//  request   start / busy         in_stream_index in_data_byte in_carries_byte
//                                 in_ends_stream
//  result    out_strobe           out_byte out_valid out_last_of_run
//                                 out_pending_bytes out_stream_closed
//  config    cfg_wr_en            cfg_wdata (window_size)
//
// A request is latched on acceptance, stored into the cell row, counted by
// the registered run counter, and the pointers settle; then one result per
// cycle goes out as the cell row shifts toward the head, one per released
// byte (a single status-only result if none), before the next acceptance.
// Reset clears all valid bits at once; no clearing pass.
// Results are one-cycle strobes; the receiver cannot stall them.
`default_nettype none

module stream_byte_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_stream_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_carries_byte,
  input  logic        in_ends_stream,
  // result
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        out_last_of_run,
  output logic [6:0]  out_pending_bytes,
  output logic        out_stream_closed,
  // config
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wdata
);
  import sbr_pkg::*;

  sbr_state_t state_r, state_nxt;

  logic [WIN_W-1:0] window_size_r;

  // latched request
  logic [POS_W-1:0] in_pos_r;
  logic [7:0]       in_dat_r;
  logic             in_has_r;
  logic             in_end_r;

  // stream state
  logic [POS_W-1:0] next_index_r;
  logic [POS_W-1:0] end_index_r;
  logic             end_known_r;
  logic             closed_flag_r;
  logic [CNT_W-1:0] pending_r;

  // per-run results
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] emit_cnt_r;
  logic [CNT_W-1:0] pending_after_r;
  logic             closed_after_r;

  // cell row
  cell_ctrl_t           ctrl [WINDOW_DEPTH];
  logic                 cell_vld [WINDOW_DEPTH];
  logic [7:0]           cell_dat [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_vec;
  logic [CNT_W-1:0]     run_len;

  // sequencer outputs
  logic accept;
  logic store_ph;
  logic fin_ph;
  logic emit_ph;
  logic last_emit;
  logic shift_en;
  logic clr_en;

  // store decision
  logic [WIN_W-1:0] win_eff;
  logic [POS_W-1:0] off;
  logic             in_win;
  logic             end_set;
  logic             end_known_new;
  logic [POS_W-1:0] end_index_new;
  logic             past_end;
  logic [IDX_W-1:0] slot;
  logic             store_ok;
  logic             closed_now;

  assign accept = start && (state_r == ST_IDLE);

  // window, clipped to the cell count
  assign win_eff = (window_size_r > WIN_W'(WINDOW_DEPTH)) ? WIN_W'(WINDOW_DEPTH)
                                                          : window_size_r;
  assign off     = in_pos_r - next_index_r;
  assign in_win  = off < POS_W'(win_eff);

  // end mark taken first, then the byte checked against it
  assign end_set       = !closed_flag_r && in_end_r && in_win && !end_known_r;
  assign end_known_new = end_known_r || end_set;
  assign end_index_new = end_set ? (in_pos_r + POS_W'(in_has_r)) : end_index_r;
  assign past_end      = end_known_new && (off >= (end_index_new - next_index_r));
  assign slot          = off[IDX_W-1:0];
  assign store_ok      = store_ph && !closed_flag_r && in_has_r && in_win &&
                         !past_end && !cell_vld[slot];

  // stream closes when next index will reach a known end
  assign closed_now = end_known_r && ((next_index_r + POS_W'(run_len)) == end_index_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_STORE;
      ST_STORE: state_nxt = ST_CNT1;
      ST_CNT1:  state_nxt = ST_CNT2;
      ST_CNT2:  state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_EMIT;
      ST_EMIT:  if (last_emit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    store_ph  = 1'b0;
    fin_ph    = 1'b0;
    emit_ph   = 1'b0;
    unique case (state_r)
      ST_IDLE:  busy     = 1'b0;
      ST_STORE: store_ph = 1'b1;
      ST_CNT1,
      ST_CNT2:  ;
      ST_FIN:   fin_ph   = 1'b1;
      ST_EMIT:  emit_ph  = 1'b1;
      default:  busy     = 1'b1;
    endcase
  end

  assign last_emit = emit_ph && ((n_r == '0) || (emit_cnt_r == (n_r - 1'b1)));
  assign shift_en  = emit_ph && (n_r != '0);
  assign clr_en    = last_emit && closed_after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_size_r <= cfg_wdata;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      in_pos_r <= in_stream_index;
      in_dat_r <= in_data_byte;
      in_has_r <= in_carries_byte;
      in_end_r <= in_ends_stream;
    end
  end

  // stream pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r  <= '0;
      end_index_r   <= '0;
      end_known_r   <= 1'b0;
      closed_flag_r <= 1'b0;
      pending_r     <= '0;
      emit_cnt_r    <= '0;
    end else begin
      if (store_ph) begin
        end_known_r <= end_known_new;
        end_index_r <= end_index_new;
        if (store_ok) begin
          pending_r <= pending_r + 1'b1;
        end
      end
      if (fin_ph) begin
        emit_cnt_r <= '0;
      end
      if (shift_en) begin
        next_index_r <= next_index_r + 1'b1;
        emit_cnt_r   <= emit_cnt_r + 1'b1;
      end
      if (last_emit) begin
        pending_r     <= pending_after_r;
        closed_flag_r <= closed_after_r;
      end
    end
  end

  // run results, settled before the first result goes out
  always_ff @(posedge clk) begin
    if (fin_ph) begin
      n_r             <= run_len;
      closed_after_r  <= closed_now;
      pending_after_r <= closed_now ? '0 : (pending_r - run_len);
    end
  end

  // cell row: cell i holds position next_index + i
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic       nb_vld;
    logic [7:0] nb_dat;

    assign ctrl[i].clr   = clr_en;
    assign ctrl[i].shift = shift_en;
    assign ctrl[i].wr    = store_ok && (slot == IDX_W'(i));
    assign ctrl[i].wdata = in_dat_r;

    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign nb_vld = 1'b0;
      assign nb_dat = 8'd0;
    end else begin : g_body
      assign nb_vld = cell_vld[i+1];
      assign nb_dat = cell_dat[i+1];
    end

    sbr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl[i]),
      .nb_vld (nb_vld),
      .nb_dat (nb_dat),
      .vld    (cell_vld[i]),
      .dat    (cell_dat[i])
    );

    assign vld_vec[i] = cell_vld[i];
  end

  sbr_run_count u_run (
    .clk     (clk),
    .vld_vec (vld_vec),
    .run_len (run_len)
  );

  // result ports
  assign out_strobe        = emit_ph;
  assign out_valid         = (n_r != '0);
  assign out_byte          = (n_r != '0) ? cell_dat[0] : 8'd0;
  assign out_last_of_run   = last_emit;
  assign out_pending_bytes = 7'(pending_after_r);
  assign out_stream_closed = closed_after_r;

endmodule

`default_nettype wire

@@ sv/sbr_checker.sv @@
// Port-level checks for the stream byte reassembler, bound to the top.
// Depends on the top level's port list only.
`default_nettype none

module sbr_port_props (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        out_strobe,
  input  logic        out_valid,
  input  logic        out_last_of_run,
  input  logic [6:0]  out_pending_bytes,
  input  logic        out_stream_closed
);

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // results only while a request is in work
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // a status-only result is the only result of its run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid |-> out_last_of_run)
    else $error("status-only result not marked last");

  // a run continues without gaps until its last byte
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_of_run |=> out_strobe && out_valid)
    else $error("release run interrupted");

  // a closed stream holds nothing
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_stream_closed |-> out_pending_bytes == 7'd0)
    else $error("bytes pending on closed stream");

endmodule

bind stream_byte_reassembler sbr_port_props u_sbr_props (.*);

`default_nettype wire
